FILE: rtl/dasg_pkg.sv
package dasg_pkg;

  // Request kinds carried by one input transfer.
  typedef enum logic {
    REQ_SET  = 1'b0,
    REQ_TICK = 1'b1
  } req_type_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_DIAL_MAX  = 2'd0,
    CFG_DIAL_MIN  = 2'd1,
    CFG_ANGLE_MAX = 2'd2,
    CFG_ANGLE_MIN = 2'd3
  } cfg_idx_e;

  localparam int unsigned CfgWidth = 8;
  localparam int unsigned PosWidth = 8;
  localparam int unsigned PerWidth = 16;

  // Reset values of the clamp limits.
  localparam logic signed [CfgWidth-1:0] DialMaxRst  = 8'sd100;
  localparam logic signed [CfgWidth-1:0] DialMinRst  = -8'sd100;
  localparam logic signed [CfgWidth-1:0] AngleMaxRst = 8'sd50;
  localparam logic signed [CfgWidth-1:0] AngleMinRst = 8'sd0;

  // One input item.
  typedef struct packed {
    req_type_e                    req_type;
    logic signed [PosWidth-1:0]   dial_goal;
    logic signed [PosWidth-1:0]   angle_goal;
    logic        [PerWidth-1:0]   tick_period;
  } in_t;

  // One result item.
  typedef struct packed {
    logic                         dial_step;
    logic                         dial_dir;
    logic                         angle_step;
    logic                         angle_dir;
    logic signed [PosWidth-1:0]   dial_position;
    logic signed [PosWidth-1:0]   angle_position;
    logic                         busy_res;
  } out_t;

endpackage

FILE: rtl/dasg_outbuf.sv
module dasg_outbuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dasg_pkg::out_t  push_data_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output dasg_pkg::out_t  out_data_o
);
  import dasg_pkg::*;

  logic main_vld_q, main_vld_d;
  logic skid_vld_q, skid_vld_d;
  out_t main_q, main_d;
  out_t skid_q, skid_d;
  logic pop;

  assign pop         = main_vld_q && !out_stall_i;
  assign full_o      = skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;

  // Main register feeds the output; the skid register catches a transfer
  // that arrives while the main result is still stalled.
  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (pop) begin
      main_vld_d = skid_vld_q;
      main_d     = skid_q;
      skid_vld_d = 1'b0;
    end
    if (push_i) begin
      if (main_vld_q && out_stall_i) begin
        skid_vld_d = 1'b1;
        skid_d     = push_data_i;
      end else begin
        main_vld_d = 1'b1;
        main_d     = push_data_i;
      end
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  // The skid register is only ever occupied behind a waiting main result.
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> main_vld_q)
    else $error("skid entry without main entry");

  // A transfer arriving on a stalled main result lands in the skid register.
  a_push_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && main_vld_q && out_stall_i |=> skid_vld_q)
    else $error("result lost behind stalled output");

  // Upstream is held off whenever the skid register is occupied.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> !push_i)
    else $error("push into full output buffer");

endmodule

FILE: rtl/dual_axis_step_dir_generator_core.sv
// A result is registered in the output buffer's main or, while stalled, skid register.
// Throughput: one item per cycle while in_stall_o is low; the step/position state
// updates in the same cycle the item is accepted, so items may follow back to back.
// A two-entry output buffer takes one more transfer while a result is stalled.
// Reset (rst_ni low, asynchronous) clears positions, counts and the timer,
// sets both directions forward and loads the default clamp limits.
module dual_axis_step_dir_generator_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  dasg_pkg::cfg_idx_e   cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dasg_pkg::in_t        in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dasg_pkg::out_t       out_data_o
);
  import dasg_pkg::*;

  typedef struct packed {
    logic                       fwd;
    logic [PosWidth-1:0]        left;
  } plan_t;

  logic signed [CfgWidth-1:0] dial_max_q, dial_min_q, angle_max_q, angle_min_q;

  logic signed [PosWidth-1:0] dial_pos_q, dial_pos_d, angle_pos_q, angle_pos_d;
  logic [PosWidth-1:0]        dial_left_q, dial_left_d, angle_left_q, angle_left_d;
  logic                       dial_fwd_q, dial_fwd_d, angle_fwd_q, angle_fwd_d;
  logic [PerWidth-1:0]        period_hold_q, period_hold_d;
  logic [PerWidth-1:0]        divider_q, divider_d;
  logic                       running_q, running_d;

  logic                       accept;
  logic                       dial_step, angle_step;
  logic [PerWidth-1:0]        per_eff, cnt_inc;
  plan_t                      dial_plan, angle_plan;
  out_t                       result;

  // Clamp a goal to [lo, hi] (lo wins when inverted) and plan the move.
  function automatic plan_t plan_axis(logic signed [PosWidth-1:0] goal,
                                      logic signed [PosWidth-1:0] hi,
                                      logic signed [PosWidth-1:0] lo,
                                      logic signed [PosWidth-1:0] pos);
    logic signed [PosWidth-1:0] g;
    logic signed [PosWidth:0]   delta;
    logic        [PosWidth:0]   mag;
    plan_t                      p;
    g = goal;
    if (g > hi) g = hi;
    if (g < lo) g = lo;
    delta = {g[PosWidth-1], g} - {pos[PosWidth-1], pos};
    mag   = delta[PosWidth] ? (~delta + 1'b1) : delta;
    p.fwd  = !delta[PosWidth] && (delta != '0);
    p.left = mag[PosWidth-1:0];
    return p;
  endfunction

  assign accept = in_valid_i && !in_stall_o;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dial_max_q  <= DialMaxRst;
      dial_min_q  <= DialMinRst;
      angle_max_q <= AngleMaxRst;
      angle_min_q <= AngleMinRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DIAL_MAX:  dial_max_q  <= cfg_wdata_i;
        CFG_DIAL_MIN:  dial_min_q  <= cfg_wdata_i;
        CFG_ANGLE_MAX: angle_max_q <= cfg_wdata_i;
        CFG_ANGLE_MIN: angle_min_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign dial_plan  = plan_axis(in_data_i.dial_goal, dial_max_q, dial_min_q, dial_pos_q);
  assign angle_plan = plan_axis(in_data_i.angle_goal, angle_max_q, angle_min_q,
                                angle_pos_q);
  assign per_eff    = (period_hold_q == '0) ? PerWidth'(1) : period_hold_q;
  assign cnt_inc    = divider_q + PerWidth'(1);

  // Next state for a set or tick request.
  always_comb begin
    dial_pos_d    = dial_pos_q;
    angle_pos_d   = angle_pos_q;
    dial_left_d   = dial_left_q;
    angle_left_d  = angle_left_q;
    dial_fwd_d    = dial_fwd_q;
    angle_fwd_d   = angle_fwd_q;
    period_hold_d = period_hold_q;
    divider_d     = divider_q;
    running_d     = running_q;
    dial_step     = 1'b0;
    angle_step    = 1'b0;
    if (in_data_i.req_type == REQ_SET) begin
      dial_fwd_d   = dial_plan.fwd;
      dial_left_d  = dial_plan.left;
      angle_fwd_d  = angle_plan.fwd;
      angle_left_d = angle_plan.left;
      if (dial_plan.left != '0 || angle_plan.left != '0) begin
        period_hold_d = (in_data_i.tick_period == '0) ? PerWidth'(1)
                                                      : in_data_i.tick_period;
        divider_d     = '0;
        running_d     = 1'b1;
      end
    end else if (running_q) begin
      divider_d = cnt_inc;
      if (cnt_inc >= per_eff) begin
        divider_d = '0;
        if (dial_left_q != '0) begin
          dial_step   = 1'b1;
          dial_left_d = dial_left_q - 1'b1;
          dial_pos_d  = dial_fwd_q ? dial_pos_q + 8'sd1 : dial_pos_q - 8'sd1;
        end
        if (angle_left_q != '0) begin
          angle_step   = 1'b1;
          angle_left_d = angle_left_q - 1'b1;
          angle_pos_d  = angle_fwd_q ? angle_pos_q + 8'sd1 : angle_pos_q - 8'sd1;
        end
        if (dial_left_d == '0 && angle_left_d == '0) running_d = 1'b0;
      end
    end
  end

  // Result of this item.
  always_comb begin
    result.dial_step      = dial_step;
    result.dial_dir       = dial_fwd_d;
    result.angle_step     = angle_step;
    result.angle_dir      = angle_fwd_d;
    result.dial_position  = dial_pos_d;
    result.angle_position = angle_pos_d;
    result.busy_res       = running_d;
  end

  // Axis and timer state, updated on each accepted transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dial_pos_q    <= '0;
      angle_pos_q   <= '0;
      dial_left_q   <= '0;
      angle_left_q  <= '0;
      dial_fwd_q    <= 1'b1;
      angle_fwd_q   <= 1'b1;
      period_hold_q <= '0;
      divider_q     <= '0;
      running_q     <= 1'b0;
    end else if (accept) begin
      dial_pos_q    <= dial_pos_d;
      angle_pos_q   <= angle_pos_d;
      dial_left_q   <= dial_left_d;
      angle_left_q  <= angle_left_d;
      dial_fwd_q    <= dial_fwd_d;
      angle_fwd_q   <= angle_fwd_d;
      period_hold_q <= period_hold_d;
      divider_q     <= divider_d;
      running_q     <= running_d;
    end
  end

  // Result buffering toward the output channel.
  dasg_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (result),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A stopped timer never has steps outstanding.
  a_idle_no_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (dial_left_q == '0 && angle_left_q == '0))
    else $error("steps left while timer stopped");

  // While running, the divider stays below the held period.
  a_divider_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (period_hold_q != '0 && divider_q < period_hold_q))
    else $error("divider out of range");

  // A dial step consumes one count from the dial axis.
  a_step_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && dial_step |=> dial_left_q == $past(dial_left_q) - 1'b1)
    else $error("dial step without count decrement");

endmodule
